// ===== hdl/bca_pkg.sv =====
`default_nettype none

package bca_pkg;

   localparam int SAMPLE_W           = 12;
   localparam int OFFSET_W           = 13;
   localparam int WINDOW_LEN_DEFAULT = 32;
   localparam int CSR_DATA_W         = 32;
   localparam int CSR_ADDR_W         = 3;

   localparam logic [SAMPLE_W-1:0] CENTRE_RESET = 12'd2048;

   // Q1.11: 2048 stands for +1.0
   localparam logic signed [OFFSET_W-1:0] Q_ONE     = 13'sd2048;
   localparam logic signed [OFFSET_W-1:0] Q_NEG_ONE = -13'sd2048;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_CENTRE = 1'b0;

   typedef struct packed {
      logic take;      // item accepted this cycle
      logic wrapped;   // every ring entry has been written at least once
   } axis_ctrl_type;

   // mean minus centre, saturated to +/-1.0
   function automatic logic signed [OFFSET_W-1:0] centre_offset(
      input logic [SAMPLE_W-1:0] avg,
      input logic [SAMPLE_W-1:0] centre
   );
      logic signed [OFFSET_W-1:0] diff;
      diff = $signed({1'b0, avg}) - $signed({1'b0, centre});
      if (diff > Q_ONE) begin
         diff = Q_ONE;
      end else if (diff < Q_NEG_ONE) begin
         diff = Q_NEG_ONE;
      end
      return diff;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/dual_axis_boxcar_average_core.sv =====
// A result passes through the running-sum register and then the result register.
// Throughput: one item per cycle while the input is not stalled; the single write and
// single prefetch read per cycle on each axis ring set the pace.
// Reset is synchronous and active high; rings read as zero until filled once,
// sums and ring position clear, centre returns to 2048.
`default_nettype none

module dual_axis_boxcar_average_core #(
   parameter int WINDOW_LEN = bca_pkg::WINDOW_LEN_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input item
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [bca_pkg::SAMPLE_W-1:0]      req_x_sample,
   input  wire logic [bca_pkg::SAMPLE_W-1:0]      req_y_sample,
   // result item
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [bca_pkg::SAMPLE_W-1:0]           rsp_x_average,
   output logic [bca_pkg::SAMPLE_W-1:0]           rsp_y_average,
   output logic signed [bca_pkg::OFFSET_W-1:0]    rsp_x_offset,
   output logic signed [bca_pkg::OFFSET_W-1:0]    rsp_y_offset,
   // register port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [bca_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [bca_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bca_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);
   import bca_pkg::*;

   localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);

   // ---------------------------------------------------------------------
   // Register port: centre value at index 0, everything else reads zero
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0] centre_ff;
   logic [SAMPLE_W-1:0] centre_in;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      centre_in = centre_ff;
      if (csr_write && (paddr[2] == CSR_IDX_CENTRE)) begin
         centre_in = pwdata[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff <= CENTRE_RESET;
      end else begin
         centre_ff <= centre_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_CENTRE) begin
         prdata = CSR_DATA_W'(centre_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Flow control. Stage 1 is the running-sum register inside each axis;
   // stage 2 is the result register. Stall the input only when stage 1
   // holds an item that cannot move into a blocked result register.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic take;
   logic s1_move;
   logic out_blocked;

   assign out_blocked  = out_valid_ff && rsp_stall;
   assign s1_move      = s1_valid_ff && !out_blocked;
   assign req_stall    = s1_valid_ff && out_blocked;
   assign take         = req_valid && !req_stall;
   assign s1_valid_in  = take || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || out_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Shared ring position. The wrapped flag marks the first full lap, after
   // which every entry holds a real sample; before that the entry about to
   // be replaced has never been written and counts as zero.
   // ---------------------------------------------------------------------
   logic [PTR_W-1:0] ptr_ff, ptr_in, ptr_next;
   logic             wrapped_ff, wrapped_in;
   logic [PTR_W-1:0] rd_ptr;
   axis_ctrl_type    axis_ctrl;

   assign ptr_next   = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);
   assign ptr_in     = take ? ptr_next : ptr_ff;
   assign wrapped_in = wrapped_ff || (take && (ptr_ff == PTR_LAST));
   // prefetch the entry the following item will replace
   assign rd_ptr     = take ? ptr_next : ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         ptr_ff     <= ptr_in;
         wrapped_ff <= wrapped_in;
      end
   end

   assign axis_ctrl.take    = take;
   assign axis_ctrl.wrapped = wrapped_ff;

   // ---------------------------------------------------------------------
   // Per-axis ring, running sum and mean
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0] x_mean, y_mean;

   bca_axis #(
      .WINDOW_LEN (WINDOW_LEN),
      .PTR_W      (PTR_W)
   ) u_x_axis (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (axis_ctrl),
      .wr_ptr  (ptr_ff),
      .rd_ptr  (rd_ptr),
      .sample  (req_x_sample),
      .average (x_mean)
   );

   bca_axis #(
      .WINDOW_LEN (WINDOW_LEN),
      .PTR_W      (PTR_W)
   ) u_y_axis (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (axis_ctrl),
      .wr_ptr  (ptr_ff),
      .rd_ptr  (rd_ptr),
      .sample  (req_y_sample),
      .average (y_mean)
   );

   // ---------------------------------------------------------------------
   // Result register: load the means and their centred offsets
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0]        x_avg_ff, y_avg_ff;
   logic signed [OFFSET_W-1:0] x_off_ff, y_off_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         x_avg_ff <= x_mean;
         y_avg_ff <= y_mean;
         x_off_ff <= centre_offset(x_mean, centre_ff);
         y_off_ff <= centre_offset(y_mean, centre_ff);
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_x_average = x_avg_ff;
   assign rsp_y_average = y_avg_ff;
   assign rsp_x_offset  = x_off_ff;
   assign rsp_y_offset  = y_off_ff;

endmodule

`default_nettype wire

// ===== hdl/bca_axis.sv =====
`default_nettype none

module bca_axis #(
   parameter int WINDOW_LEN = bca_pkg::WINDOW_LEN_DEFAULT,
   parameter int PTR_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bca_pkg::axis_ctrl_type        ctrl,
   input  wire logic [PTR_W-1:0]              wr_ptr,
   input  wire logic [PTR_W-1:0]              rd_ptr,
   input  wire logic [bca_pkg::SAMPLE_W-1:0]  sample,
   output logic      [bca_pkg::SAMPLE_W-1:0]  average
);
   import bca_pkg::*;

   localparam int  SUM_W     = SAMPLE_W + PTR_W;
   localparam bit  POW2      = (WINDOW_LEN & (WINDOW_LEN - 1)) == 0;
   localparam int  DIV_SHIFT = SUM_W + PTR_W;
   localparam int  RECIP_W   = SUM_W + 1;
   localparam longint unsigned RECIP = ((64'd1 << DIV_SHIFT) / WINDOW_LEN) + 64'd1;

   logic [SAMPLE_W-1:0] ring_mem [WINDOW_LEN];
   logic [SAMPLE_W-1:0] old_ff;
   logic [SAMPLE_W-1:0] old_sample;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;

   // write the new sample, prefetch the entry the next item will replace
   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         ring_mem[wr_ptr] <= sample;
      end
      old_ff <= ring_mem[rd_ptr];
   end

   // entries not yet written count as zero
   assign old_sample = ctrl.wrapped ? old_ff : '0;

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.take) begin
         sum_in = sum_ff - SUM_W'(old_sample) + SUM_W'(sample);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   generate
      if (POW2) begin : g_shift
         assign average = sum_ff[PTR_W +: SAMPLE_W];
      end else begin : g_recip
         // exact floor division by multiply with a rounded-up reciprocal
         logic [SUM_W+RECIP_W-1:0] product;
         assign product = (SUM_W+RECIP_W)'(sum_ff) * (SUM_W+RECIP_W)'(RECIP_W'(RECIP));
         assign average = product[DIV_SHIFT +: SAMPLE_W];
      end
   endgenerate

endmodule

`default_nettype wire

// ===== hdl/bca_checker.sv =====
`default_nettype none

module bca_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [bca_pkg::SAMPLE_W-1:0]      rsp_x_average,
   input wire logic [bca_pkg::SAMPLE_W-1:0]      rsp_y_average,
   input wire logic signed [bca_pkg::OFFSET_W-1:0] rsp_x_offset,
   input wire logic signed [bca_pkg::OFFSET_W-1:0] rsp_y_offset
);
   import bca_pkg::*;

   // input held back only when a result is waiting on a stalled output
   a_stall_only_when_blocked : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output free");

   // a stalled result stays and holds its payload
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_x_average)
         && $stable(rsp_y_average) && $stable(rsp_x_offset) && $stable(rsp_y_offset)))
      else $error("stalled result changed");

   // offsets saturate at plus or minus one
   a_offset_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_x_offset <= Q_ONE) && (rsp_x_offset >= Q_NEG_ONE)
         && (rsp_y_offset <= Q_ONE) && (rsp_y_offset >= Q_NEG_ONE)))
      else $error("offset out of range");

   // no result straight out of reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind dual_axis_boxcar_average_core bca_checker u_bca_checker (.*);

`default_nettype wire
